// ===== hw/rtl/wet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wet_pkg;

	localparam int NEURONS_DEF   = 256;
	localparam int MAX_EDGES_DEF = 16;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ZERO  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	typedef struct packed {
		logic [15:0]        target_neuron;
		logic [7:0]         tgt_rank;
		logic [15:0]        source_neuron;
		logic [7:0]         src_rank;
		logic signed [15:0] delta_weight;
	} wet_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        target_touched;
		logic [4:0]  target_in_entries;
		logic [18:0] target_excitatory_sum;
		logic [19:0] target_inhibitory_sum;
		logic        source_touched;
		logic [19:0] source_out_total;
	} wet_result_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic commit;
	} wet_ctrl_t;

	typedef struct packed {
		logic        full;
		logic [4:0]  entries;
		logic [18:0] exc;
		logic [19:0] inh;
		logic [19:0] tot;
	} wet_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} wet_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wet_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wet_list #(
	parameter int NEURONS   = wet_pkg::NEURONS_DEF,
	parameter int MAX_EDGES = wet_pkg::MAX_EDGES_DEF,
	localparam int NB = (NEURONS > 1) ? $clog2(NEURONS) : 1,
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wet_pkg::wet_ctrl_t ctrl,
	input  wire logic [NB-1:0]     clr_idx,
	input  wire logic [EB-1:0]     rd_idx,
	input  wire logic [15:0]       nidx_in,
	input  wire logic [7:0]        key_rank,
	input  wire logic [15:0]       key_neuron,
	input  wire logic signed [15:0] delta,
	output wet_pkg::wet_stat_t     stat
);
	import wet_pkg::*;

	localparam int CW    = $clog2(MAX_EDGES + 1);
	localparam int DEPTH = NEURONS * MAX_EDGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = 16 + CW;

	typedef struct packed {
		logic [7:0]         rank;
		logic [15:0]        neuron;
		logic signed [15:0] weight;
	} edge_t;

	function automatic logic [SW-1:0] wpos(input logic signed [15:0] w);
		return w[15] ? '0 : SW'({1'b0, w[14:0]});
	endfunction

	function automatic logic [SW-1:0] wneg(input logic signed [15:0] w);
		logic [16:0] m;
		m = 17'(0) - {w[15], w};
		return w[15] ? SW'(m) : '0;
	endfunction

	edge_t         edge_mem [DEPTH];
	logic [CW-1:0] cnt_mem  [NEURONS];

	edge_t              edge_rd;
	logic [CW-1:0]      cnt_rd;
	logic [NB-1:0]      nidx_q;
	logic [7:0]         rank_q;
	logic [15:0]        neuron_q;
	logic signed [15:0] delta_q;
	logic [AW-1:0]      base_q;
	logic               found_q;
	logic [EB-1:0]      pos_q;
	logic signed [15:0] wold_q;
	edge_t              last_q;
	logic [SW-1:0]      exs_q;
	logic [SW-1:0]      inh_q;
	logic               scan_s1;
	logic [EB-1:0]      idx_s1;

	logic               in_cnt;
	logic               hit;
	logic signed [16:0] ssum;
	logic signed [15:0] snew;
	logic               remove;
	logic signed [15:0] wnew;
	logic [SW-1:0]      exs_new;
	logic [SW-1:0]      inh_new;
	logic [CW-1:0]      cnt_new;
	logic [AW-1:0]      wr_addr;
	edge_t              wr_data;

	// scan bookkeeping
	assign in_cnt = CW'(idx_s1) < cnt_rd;
	assign hit    = in_cnt && (edge_rd.rank == rank_q) && (edge_rd.neuron == neuron_q);

	// update decision
	always_comb begin
		ssum = {wold_q[15], wold_q} + {delta_q[15], delta_q};
		if (ssum[16] != ssum[15]) begin
			snew = ssum[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			snew = ssum[15:0];
		end
		remove  = found_q && (snew == 16'sd0);
		wnew    = found_q ? snew : delta_q;
		exs_new = exs_q - (found_q ? wpos(wold_q) : '0) + (remove ? '0 : wpos(wnew));
		inh_new = inh_q - (found_q ? wneg(wold_q) : '0) + (remove ? '0 : wneg(wnew));
		if (remove) begin
			cnt_new = cnt_rd - 1'b1;
		end else if (found_q) begin
			cnt_new = cnt_rd;
		end else begin
			cnt_new = cnt_rd + 1'b1;
		end
		wr_addr = base_q + AW'(found_q ? pos_q : cnt_rd[EB-1:0]);
		wr_data = remove ? last_q : edge_t'{rank: rank_q, neuron: neuron_q, weight: wnew};
	end

	always_comb begin
		stat.full    = (cnt_rd >= CW'(MAX_EDGES)) && !found_q;
		stat.entries = 5'(cnt_new);
		stat.exc     = 19'(exs_new);
		stat.inh     = 20'(inh_new);
		stat.tot     = 20'(exs_new + inh_new);
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			edge_mem[wr_addr] <= wr_data;
		end
		if (ctrl.scan) begin
			edge_rd <= edge_mem[base_q + AW'(rd_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			cnt_mem[clr_idx] <= '0;
		end else if (ctrl.commit) begin
			cnt_mem[nidx_q] <= cnt_new;
		end
		if (ctrl.load) begin
			cnt_rd <= cnt_mem[nidx_in[NB-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			scan_s1 <= ctrl.scan;
			if (ctrl.load) begin
				found_q <= 1'b0;
			end else if (scan_s1 && hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (ctrl.load) begin
			nidx_q   <= nidx_in[NB-1:0];
			rank_q   <= key_rank;
			neuron_q <= key_neuron;
			delta_q  <= delta;
			base_q   <= AW'(nidx_in[NB-1:0]) * AW'(MAX_EDGES);
			exs_q    <= '0;
			inh_q    <= '0;
		end else if (scan_s1) begin
			if (hit && !found_q) begin
				pos_q  <= idx_s1;
				wold_q <= edge_rd.weight;
			end
			if (in_cnt) begin
				exs_q <= exs_q + wpos(edge_rd.weight);
				inh_q <= inh_q + wneg(edge_rd.weight);
				if (CW'(idx_s1) == cnt_rd - 1'b1) begin
					last_q <= edge_rd;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_edge_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Weighted edge table. Each command adds a signed weight to one edge and updates
// the in-list of a local target and the out-list of a local source, each kept in
// its own single-port edge memory with a per-neuron count memory. A command is
// taken when start is high and busy is low; the result appears on result for
// exactly one cycle with done high, and the receiver cannot stall it. Every
// command scans all MAX_EDGES entries through the edge memory read port, one per
// cycle, then passes a drain state and a write-back state before done; the next
// command can be taken in the done cycle. After reset a clearing pass over all
// NEURONS entries zeroes the count memories while busy is high; local_rank writes
// are taken at any time.
module weighted_edge_table_core #(
	parameter int NEURONS   = wet_pkg::NEURONS_DEF,
	parameter int MAX_EDGES = wet_pkg::MAX_EDGES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire wet_pkg::wet_cmd_t   cmd,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data,
	output logic                     done,
	output wet_pkg::wet_result_t     result
);
	import wet_pkg::*;

	localparam int NB = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	wet_state_t  state_q;
	wet_state_t  state_nxt;
	logic [7:0]  local_rank_q;
	wet_cmd_t    item_q;
	logic [NB-1:0] clr_idx_q;
	logic [EB-1:0] rd_idx_q;
	wet_result_t result_q;
	logic        done_q;

	wet_ctrl_t   t_ctrl;
	wet_ctrl_t   s_ctrl;
	wet_stat_t   t_stat;
	wet_stat_t   s_stat;

	logic        accept;
	logic        tloc;
	logic        sloc;
	logic [1:0]  status;
	wet_result_t result_nxt;

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign tloc = item_q.tgt_rank == local_rank_q;
	assign sloc = item_q.src_rank == local_rank_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == NB'(NEURONS - 1)) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (rd_idx_q == EB'(MAX_EDGES - 1)) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// status of the transaction
	always_comb begin
		priority if (item_q.delta_weight == 16'sd0) begin
			status = STAT_ZERO;
		end else if ((tloc && ({1'b0, item_q.target_neuron} >= 17'(NEURONS))) ||
				(sloc && ({1'b0, item_q.source_neuron} >= 17'(NEURONS)))) begin
			status = STAT_RANGE;
		end else if ((tloc && t_stat.full) || (sloc && s_stat.full)) begin
			status = STAT_FULL;
		end else begin
			status = STAT_OK;
		end
	end

	// control outputs
	always_comb begin
		busy          = state_q != ST_IDLE;
		accept        = (state_q == ST_IDLE) && start;
		t_ctrl.clear  = state_q == ST_CLEAR;
		t_ctrl.load   = accept;
		t_ctrl.scan   = state_q == ST_SCAN;
		t_ctrl.commit = (state_q == ST_DECIDE) && (status == STAT_OK) && tloc;
		s_ctrl        = t_ctrl;
		s_ctrl.commit = (state_q == ST_DECIDE) && (status == STAT_OK) && sloc;
	end

	always_comb begin
		result_nxt        = '0;
		result_nxt.status = status;
		if (status == STAT_OK) begin
			if (tloc) begin
				result_nxt.target_touched        = 1'b1;
				result_nxt.target_in_entries     = t_stat.entries;
				result_nxt.target_excitatory_sum = t_stat.exc;
				result_nxt.target_inhibitory_sum = t_stat.inh;
			end
			if (sloc) begin
				result_nxt.source_touched   = 1'b1;
				result_nxt.source_out_total = s_stat.tot;
			end
		end
	end

	wet_list #(
		.NEURONS   (NEURONS),
		.MAX_EDGES (MAX_EDGES)
	) u_in_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (t_ctrl),
		.clr_idx    (clr_idx_q),
		.rd_idx     (rd_idx_q),
		.nidx_in    (cmd.target_neuron),
		.key_rank   (cmd.src_rank),
		.key_neuron (cmd.source_neuron),
		.delta      (cmd.delta_weight),
		.stat       (t_stat)
	);

	wet_list #(
		.NEURONS   (NEURONS),
		.MAX_EDGES (MAX_EDGES)
	) u_out_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (s_ctrl),
		.clr_idx    (clr_idx_q),
		.rd_idx     (rd_idx_q),
		.nidx_in    (cmd.source_neuron),
		.key_rank   (cmd.tgt_rank),
		.key_neuron (cmd.target_neuron),
		.delta      (cmd.delta_weight),
		.stat       (s_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			local_rank_q <= 8'd0;
			clr_idx_q    <= '0;
			rd_idx_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= state_q == ST_DECIDE;
			if (cfg_valid && cfg_ready) begin
				local_rank_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_SCAN) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (state_q == ST_DECIDE) begin
			result_q <= result_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import wet_pkg::*;

	localparam int NEURONS     = NEURONS_DEF;
	localparam int MAX_EDGES   = MAX_EDGES_DEF;
	localparam int IN_LIST     = 0;
	localparam int OUT_LIST    = 1;
	localparam int PHASE_ITEMS = 340;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {
		PLAN_ITEM,
		PLAN_CFG,
		PLAN_DRAIN,
		PLAN_GAP
	} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		wet_cmd_t   cmd;
		logic [7:0] rank;
		int         gap_pct;
	} plan_step_t;

	typedef struct {
		logic [7:0]  rank;
		logic [15:0] neuron;
		int          weight;
	} link_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	wet_cmd_t    cmd       = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;
	logic        done;
	wet_result_t result;

	plan_step_t  plan_q[$];
	wet_result_t predicted_totals_q[$];
	link_t       link_store[2][NEURONS][MAX_EDGES];
	int          link_cnt[2][NEURONS] = '{default: 0};
	logic [7:0]  model_rank = 8'd0;
	int          edge_weight_hint[logic [47:0]];
	int          gap_pct      = 0;
	int          mismatches   = 0;
	int          quiet_cycles = 0;

	weighted_edge_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int find_link(int l, int n, logic [7:0] rk, logic [15:0] nr);
		for (int i = 0; i < link_cnt[l][n]; i++)
			if (link_store[l][n][i].rank == rk && link_store[l][n][i].neuron == nr)
				return i;
		return -1;
	endfunction

	function automatic logic list_full(int l, int n, logic [7:0] rk, logic [15:0] nr);
		return link_cnt[l][n] >= MAX_EDGES && find_link(l, n, rk, nr) < 0;
	endfunction

	function automatic void add_link(int l, int n, logic [7:0] rk, logic [15:0] nr, int d);
		int pos;
		int s;
		pos = find_link(l, n, rk, nr);
		if (pos >= 0) begin
			s = link_store[l][n][pos].weight + d;
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
			if (s == 0) begin
				link_store[l][n][pos] = link_store[l][n][link_cnt[l][n] - 1];
				link_cnt[l][n]--;
			end else begin
				link_store[l][n][pos].weight = s;
			end
		end else if (link_cnt[l][n] < MAX_EDGES) begin
			link_store[l][n][link_cnt[l][n]] = '{rk, nr, d};
			link_cnt[l][n]++;
		end
	endfunction

	function automatic wet_result_t apply_weight_update(wet_cmd_t c);
		wet_result_t r;
		int d;
		int tn;
		int sn;
		int w;
		int ex;
		int inh;
		int tot;
		logic tloc;
		logic sloc;
		r = '0;
		d = $signed(c.delta_weight);
		tn = c.target_neuron;
		sn = c.source_neuron;
		tloc = c.tgt_rank == model_rank;
		sloc = c.src_rank == model_rank;
		if (d == 0)
			r.status = STAT_ZERO;
		else if ((tloc && tn >= NEURONS) || (sloc && sn >= NEURONS))
			r.status = STAT_RANGE;
		else if ((tloc && list_full(IN_LIST, tn, c.src_rank, c.source_neuron)) ||
			(sloc && list_full(OUT_LIST, sn, c.tgt_rank, c.target_neuron)))
			r.status = STAT_FULL;
		if (r.status != STAT_OK)
			return r;
		if (tloc) begin
			add_link(IN_LIST, tn, c.src_rank, c.source_neuron, d);
			ex = 0;
			inh = 0;
			for (int i = 0; i < link_cnt[IN_LIST][tn]; i++) begin
				w = link_store[IN_LIST][tn][i].weight;
				if (w > 0)
					ex += w;
				else
					inh -= w;
			end
			r.target_touched = 1'b1;
			r.target_in_entries = 5'(link_cnt[IN_LIST][tn]);
			r.target_excitatory_sum = 19'(ex);
			r.target_inhibitory_sum = 20'(inh);
		end
		if (sloc) begin
			add_link(OUT_LIST, sn, c.tgt_rank, c.target_neuron, d);
			tot = 0;
			for (int i = 0; i < link_cnt[OUT_LIST][sn]; i++) begin
				w = link_store[OUT_LIST][sn][i].weight;
				tot += (w < 0) ? -w : w;
			end
			r.source_touched = 1'b1;
			r.source_out_total = 20'(tot);
		end
		return r;
	endfunction

	function automatic wet_cmd_t make_cmd(logic [15:0] tn, logic [7:0] tr, logic [15:0] sn,
		logic [7:0] sr, int w);
		wet_cmd_t c;
		c.target_neuron = tn;
		c.tgt_rank = tr;
		c.source_neuron = sn;
		c.src_rank = sr;
		c.delta_weight = 16'(w);
		return c;
	endfunction

	function automatic void plan_push(plan_kind_t k, wet_cmd_t c, logic [7:0] rk, int pct);
		plan_q.push_back('{k, c, rk, pct});
	endfunction

	function automatic logic [7:0] remote_rank(logic [7:0] lr);
		logic [7:0] rk;
		rk = $urandom_range(1) ? (lr ^ 8'h01) : 8'($urandom_range(255));
		if (rk == lr)
			rk = ~lr;
		return rk;
	endfunction

	// a few hot neurons at both ends of the id range so lists fill up
	function automatic logic [15:0] hot_id();
		return 16'($urandom_range(5) + ($urandom_range(1) ? 250 : 0));
	endfunction

	function automatic logic [15:0] peer_id();
		return ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(19));
	endfunction

	function automatic wet_cmd_t random_cmd(logic [7:0] lr);
		wet_cmd_t c;
		int pick;
		int d;
		int s;
		logic [47:0] k;
		c.tgt_rank = remote_rank(lr);
		c.target_neuron = peer_id();
		c.src_rank = remote_rank(lr);
		c.source_neuron = peer_id();
		pick = $urandom_range(99);
		if (pick < 40) begin
			c.tgt_rank = lr;
			c.target_neuron = hot_id();
			c.src_rank = lr;
			c.source_neuron = $urandom_range(1) ? hot_id() : 16'($urandom_range(19));
		end else if (pick < 62) begin
			c.tgt_rank = lr;
			c.target_neuron = hot_id();
		end else if (pick < 84) begin
			c.src_rank = lr;
			c.source_neuron = $urandom_range(1) ? hot_id() : 16'($urandom_range(19));
		end else if (pick < 95 && pick >= 90) begin
			if ($urandom_range(1)) begin
				c.tgt_rank = lr;
				c.target_neuron = 16'($urandom_range(65535, NEURONS));
			end else begin
				c.src_rank = lr;
				c.source_neuron = 16'($urandom_range(65535, NEURONS));
			end
		end else if (pick >= 95) begin
			c = wet_cmd_t'({$urandom(), $urandom()});
		end
		k = {c.tgt_rank, c.target_neuron, c.src_rank, c.source_neuron};
		pick = $urandom_range(99);
		if (pick < 25 && edge_weight_hint.exists(k) && edge_weight_hint[k] != -32768) begin
			d = -edge_weight_hint[k];
		end else if (pick < 35) begin
			case ($urandom_range(3))
			0: d = 32767;
			1: d = -32768;
			2: d = 1;
			default: d = -1;
			endcase
		end else if (pick < 38) begin
			d = 0;
		end else if (pick < 70) begin
			d = int'($urandom_range(500, 1));
			if ($urandom_range(1))
				d = -d;
		end else begin
			d = int'($urandom_range(65535)) - 32768;
		end
		if (d != 0) begin
			s = (edge_weight_hint.exists(k) ? edge_weight_hint[k] : 0) + d;
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
			if (s == 0)
				edge_weight_hint.delete(k);
			else
				edge_weight_hint[k] = s;
		end
		c.delta_weight = 16'(d);
		return c;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		int w;
		logic [7:0] lr;
		// directed: error precedence, saturation, full list, swap removal
		plan_push(PLAN_ITEM, make_cmd(0, 0, 0, 0, 0), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(256, 0, 1, 9, 5), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(3, 9, 16'hFFFF, 0, -5), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(16'hFFFF, 0, 0, 0, 0), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, -32768), 0, 0);
		for (int i = 0; i < MAX_EDGES; i++) begin
			if (i == 0)
				w = 32767;
			else if (i == 1)
				w = -32768;
			else
				w = ((i % 2) ? -1 : 1) * (i + 1) * 100;
			plan_push(PLAN_ITEM, make_cmd(255, 0, 16'(i), 0, w), 0, 0);
		end
		plan_push(PLAN_ITEM, make_cmd(255, 0, 16, 0, 77), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(255, 0, 0, 0, 32767), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(255, 0, 5, 0, 600), 0, 0);
		plan_push(PLAN_ITEM, make_cmd(16'hFFFF, 8'hFF, 0, 0, 1), 0, 0);

		for (int p = 0; p < 5; p++) begin
			case (p)
			0: lr = 8'hFF;
			1: lr = 8'h00;
			2: lr = 8'h80;
			3: lr = 8'($urandom_range(255));
			default: lr = 8'h01;
			endcase
			plan_push(PLAN_CFG, '0, lr, 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 85 == 0)
					plan_push(PLAN_GAP, '0, 0, (((p + i / 85) % 3) == 0) ? 0 :
						(((p + i / 85) % 3) == 1) ? 54 : 16);
				if (i == PHASE_ITEMS / 2)
					plan_push(PLAN_DRAIN, '0, 0, 0);
				plan_push(PLAN_ITEM, random_cmd(lr), 0, 0);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (plan_q.size() != 0 || start || cfg_valid || predicted_totals_q.size() != 0)
			@(negedge clk);
		repeat (3 * (MAX_EDGES + 3)) @(posedge clk);
		if (predicted_totals_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				predicted_totals_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : drive_cmds
		logic start_n;
		logic cfg_n;
		plan_step_t step;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			start_n = start;
			cfg_n = cfg_valid;
			if (start && !busy) begin
				predicted_totals_q.push_back(apply_weight_update(cmd));
				start_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				model_rank = cfg_data;
				cfg_n = 1'b0;
			end
			if (!start_n && !cfg_n && plan_q.size() != 0) begin
				step = plan_q[0];
				case (step.kind)
				PLAN_ITEM: begin
					if ($urandom_range(99) >= gap_pct) begin
						cmd <= step.cmd;
						start_n = 1'b1;
						void'(plan_q.pop_front());
					end
				end
				PLAN_CFG: begin
					if (predicted_totals_q.size() == 0) begin
						cfg_data <= step.rank;
						cfg_n = 1'b1;
						void'(plan_q.pop_front());
					end
				end
				PLAN_DRAIN: begin
					if (predicted_totals_q.size() == 0)
						void'(plan_q.pop_front());
				end
				default: begin
					gap_pct = step.gap_pct;
					void'(plan_q.pop_front());
				end
				endcase
			end
			start <= start_n;
			cfg_valid <= cfg_n;
		end
	end

	always @(posedge clk) begin : watch_results
		wet_result_t want;
		if (arst_n && done) begin
			if (predicted_totals_q.size() == 0) begin
				$display("%0t: result transaction with none expected, actual %h", $time, result);
				mismatches++;
			end else begin
				want = predicted_totals_q.pop_front();
				check_field("status", want.status, result.status);
				check_field("target_touched", want.target_touched, result.target_touched);
				check_field("target_in_entries", want.target_in_entries,
					result.target_in_entries);
				check_field("target_excitatory_sum", want.target_excitatory_sum,
					result.target_excitatory_sum);
				check_field("target_inhibitory_sum", want.target_inhibitory_sum,
					result.target_inhibitory_sum);
				check_field("source_touched", want.source_touched, result.source_touched);
				check_field("source_out_total", want.source_out_total, result.source_out_total);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

// ===== files.f =====
hw/rtl/wet_pkg.sv
hw/rtl/wet_list.sv
hw/rtl/weighted_edge_table_core.sv
dv/tb.sv
